// ===== rtl/core/rmq_pkg.sv =====
// Shared types, sizes, codes and helper functions for the role matching queue.
package rmq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 16;
  localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int PID_BITS    = 16;
  localparam int QCOUNT_BITS = 7;
  localparam int NUM_ROLES   = 3;
  localparam int ROLE_CODES  = 4;

  typedef logic [ID_BITS-1:0]    id_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [ROLE_CODES-1:0] role_mask_t;

  typedef enum logic [1:0] {
    ACT_PUSH,
    ACT_POP_ROLE,
    ACT_POP_GROUP,
    ACT_QUERY
  } action_t;

  typedef enum logic [1:0] {
    ROLE_DEFENDER,
    ROLE_HUNTER,
    ROLE_BARD,
    ROLE_SPARE
  } role_t;

  // one of each real role
  localparam role_mask_t GROUP_MASK = 4'b0111;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    id_t   id;
    role_t role;
  } entry_t;

  typedef struct packed {
    logic       clear;
    logic       proc;
    role_mask_t mask;
  } walk_ctrl_t;

  typedef struct packed {
    cnt_t                               wptr;
    logic [NUM_ROLES-1:0]               found;
    logic [NUM_ROLES-1:0][ID_BITS-1:0]  front_id;
  } walk_stat_t;

  function automatic id_t pid_to_id(input logic [PID_BITS-1:0] pid);
    logic [ID_BITS+PID_BITS-1:0] wide;
    wide = {{ID_BITS{1'b0}}, pid};
    return wide[ID_BITS-1:0];
  endfunction

  function automatic logic [PID_BITS-1:0] id_to_pid(input id_t id);
    logic [ID_BITS+PID_BITS-1:0] wide;
    wide = {{PID_BITS{1'b0}}, id};
    return wide[PID_BITS-1:0];
  endfunction

  function automatic logic [QCOUNT_BITS-1:0] cnt_to_qcount(input cnt_t cnt);
    logic [CNT_BITS+QCOUNT_BITS-1:0] wide;
    wide = {{QCOUNT_BITS{1'b0}}, cnt};
    return wide[QCOUNT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/rmq_if.sv =====
// Valid/ready channel interfaces for request and response words.
interface rmq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] player_id;
  logic [1:0]  role;

  modport source (output valid, action, player_id, role, input ready);
  modport sink   (input valid, action, player_id, role, output ready);
endinterface

interface rmq_rsp_if;
  logic        valid;
  logic        ready;
  logic [6:0]  queue_count;
  logic        defender_found;
  logic [15:0] defender_id;
  logic        hunter_found;
  logic [15:0] hunter_id;
  logic        bard_found;
  logic [15:0] bard_id;
  logic        group_ready;
  logic        push_rejected;

  modport source (output valid, queue_count, defender_found, defender_id, hunter_found,
                  hunter_id, bard_found, bard_id, group_ready, push_rejected,
                  input ready);
  modport sink   (input valid, queue_count, defender_found, defender_id, hunter_found,
                  hunter_id, bard_found, bard_id, group_ready, push_rejected,
                  output ready);
endinterface

// ===== rtl/core/rmq_store.sv =====
// Entry memory: one write port, one registered read port.
module rmq_store (
  input  logic            clk,
  input  logic            we,
  input  rmq_pkg::addr_t  waddr,
  input  rmq_pkg::entry_t wdata,
  input  logic            re,
  input  rmq_pkg::addr_t  raddr,
  output rmq_pkg::entry_t rdata
);
  import rmq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rmq_walk.sv =====
// Compaction unit: drops the first entry of each masked role, rewrites the rest
// in place and notes the frontmost kept entry of each real role.
module rmq_walk (
  input  logic                clk,
  input  logic                rst,
  input  rmq_pkg::walk_ctrl_t ctrl,
  input  rmq_pkg::entry_t     rd_entry,
  output logic                wr_en,
  output rmq_pkg::addr_t      wr_addr,
  output rmq_pkg::entry_t     wr_entry,
  output rmq_pkg::walk_stat_t stat
);
  import rmq_pkg::*;

  cnt_t                              wptr;
  role_mask_t                        removed;
  logic [NUM_ROLES-1:0]              found;
  logic [NUM_ROLES-1:0][ID_BITS-1:0] front_id;
  logic                              drop;
  logic                              first;

  assign drop  = ctrl.mask[rd_entry.role] && !removed[rd_entry.role];
  assign first = (rd_entry.role != ROLE_SPARE) && !found[rd_entry.role];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      wptr    <= '0;
      removed <= '0;
      found   <= '0;
    end else if (ctrl.proc) begin
      if (drop) begin
        removed[rd_entry.role] <= 1'b1;
      end else begin
        wptr <= cnt_t'(wptr + 1'b1);
        if (first) begin
          found[rd_entry.role] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.proc && !drop && first) begin
      front_id[rd_entry.role] <= rd_entry.id;
    end
  end

  assign wr_en         = ctrl.proc && !drop;
  assign wr_addr       = wptr[ADDR_BITS-1:0];
  assign wr_entry      = rd_entry;
  assign stat.wptr     = wptr;
  assign stat.found    = found;
  assign stat.front_id = front_id;

endmodule

// ===== rtl/core/role_matching_queue.sv =====
// Role matching queue top level: sequencer, entry memory, compaction unit, response register.
//
// An ordered queue of up to 64 waiting entries (16-bit id plus a role: defender,
// hunter, bard, or the spare code 3). A request word pushes an entry at the
// back, removes the frontmost entry of one role, removes a full group (the
// frontmost defender, hunter and bard, only when all three wait), or only
// queries. Every request yields one response word with the count, the
// frontmost id and a found flag per role, group_ready, and push_rejected when
// a push met a full queue (that push is dropped). The block takes one request
// at a time: req.ready is high only while idle. A request runs through one
// pass over the stored entries with a single memory read port and a single
// write port: each cycle reads one entry and writes back the kept entry read
// the cycle before, so removals close up in place while the frontmost ids are
// collected. A group pop that finds all three roles runs a checking pass and
// then a removal pass. A response waiting on rsp.ready does not stop the next
// request from being taken; that request then holds in its last step until
// the response register frees. After reset the queue is empty and requests
// are taken at once.
module role_matching_queue (
  input logic    clk,
  input logic    rst,
  rmq_req_if.sink   req,
  rmq_rsp_if.source rsp
);
  import rmq_pkg::*;

  state_t     state, state_next;
  cnt_t       count, count_next;
  cnt_t       rptr, rptr_next;
  logic       rd_vld, rd_vld_next;
  logic       phase, phase_next;
  action_t    act;
  role_t      role_sel;
  logic       rejected;

  logic       accept;
  logic       full;
  logic       push_we;
  logic       load_out;
  logic       rd_en;
  role_mask_t mask;

  walk_ctrl_t ctrl;
  walk_stat_t stat;
  entry_t     rd_entry;
  entry_t     push_entry;
  logic       walk_we;
  addr_t      walk_addr;
  entry_t     walk_entry;

  logic       mem_we;
  addr_t      mem_waddr;
  entry_t     mem_wdata;

  // no word is taken while reset is held
  assign req.ready = (state == ST_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign full      = (count == cnt_t'(QUEUE_DEPTH));

  assign push_entry.id   = pid_to_id(req.player_id);
  assign push_entry.role = role_t'(req.role);

  // pop-role removes the first of one role; the group's second pass removes one of each
  always_comb begin
    mask = '0;
    if (act == ACT_POP_ROLE) begin
      mask[role_sel] = 1'b1;
    end else if (act == ACT_POP_GROUP && phase) begin
      mask = GROUP_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rptr   <= '0;
      rd_vld <= 1'b0;
      phase  <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rptr   <= rptr_next;
      rd_vld <= rd_vld_next;
      phase  <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= action_t'(req.action);
      role_sel <= role_t'(req.role);
      rejected <= (action_t'(req.action) == ACT_PUSH) && full;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    rptr_next   = rptr;
    rd_vld_next = 1'b0;
    phase_next  = phase;
    push_we     = 1'b0;
    load_out    = 1'b0;
    rd_en       = 1'b0;
    ctrl.clear  = 1'b0;
    ctrl.proc   = rd_vld;
    ctrl.mask   = mask;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          ctrl.clear = 1'b1;
          rptr_next  = '0;
          phase_next = 1'b0;
          state_next = ST_WALK;
          if (action_t'(req.action) == ACT_PUSH && !full) begin
            push_we    = 1'b1;
            count_next = cnt_t'(count + 1'b1);
          end
        end
      end
      ST_WALK: begin
        if (rptr < count) begin
          rd_en       = 1'b1;
          rd_vld_next = 1'b1;
          rptr_next   = cnt_t'(rptr + 1'b1);
        end else if (!rd_vld) begin
          // pass finished: the write pointer is the new count
          count_next = stat.wptr;
          if (act == ACT_POP_GROUP && !phase && (&stat.found)) begin
            phase_next = 1'b1;
            ctrl.clear = 1'b1;
            rptr_next  = '0;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!rsp.valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // push and walk never write in the same cycle
  assign mem_we    = push_we || walk_we;
  assign mem_waddr = push_we ? count[ADDR_BITS-1:0] : walk_addr;
  assign mem_wdata = push_we ? push_entry : walk_entry;

  rmq_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rptr[ADDR_BITS-1:0]),
    .rdata (rd_entry)
  );

  rmq_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .rd_entry (rd_entry),
    .wr_en    (walk_we),
    .wr_addr  (walk_addr),
    .wr_entry (walk_entry),
    .stat     (stat)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.queue_count    <= cnt_to_qcount(count);
      rsp.defender_found <= stat.found[ROLE_DEFENDER];
      rsp.defender_id    <= stat.found[ROLE_DEFENDER] ?
                            id_to_pid(stat.front_id[ROLE_DEFENDER]) : '0;
      rsp.hunter_found   <= stat.found[ROLE_HUNTER];
      rsp.hunter_id      <= stat.found[ROLE_HUNTER] ?
                            id_to_pid(stat.front_id[ROLE_HUNTER]) : '0;
      rsp.bard_found     <= stat.found[ROLE_BARD];
      rsp.bard_id        <= stat.found[ROLE_BARD] ?
                            id_to_pid(stat.front_id[ROLE_BARD]) : '0;
      rsp.group_ready    <= &stat.found;
      rsp.push_rejected  <= rejected;
    end
  end

endmodule

// ===== rtl/core/rmq_check.sv =====
// Port-level checks for the role matching queue, bound to the top level.
module rmq_check (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic [6:0]  queue_count,
  input logic        defender_found,
  input logic [15:0] defender_id,
  input logic        hunter_found,
  input logic [15:0] hunter_id,
  input logic        bard_found,
  input logic [15:0] bard_id,
  input logic        group_ready,
  input logic        push_rejected
);
  import rmq_pkg::*;

  localparam logic [QCOUNT_BITS-1:0] FULL_COUNT = QCOUNT_BITS'(QUEUE_DEPTH);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a request is in work");

  a_group_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> group_ready == (defender_found && hunter_found && bard_found))
    else $error("group_ready disagrees with found flags");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (defender_found || defender_id == '0) &&
                  (hunter_found || hunter_id == '0) && (bard_found || bard_id == '0))
    else $error("id reported for an absent role");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && push_rejected |-> queue_count == FULL_COUNT)
    else $error("push rejected with room in the queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> queue_count <= FULL_COUNT)
    else $error("count beyond depth");

endmodule

bind role_matching_queue rmq_check u_rmq_check (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .queue_count    (rsp.queue_count),
  .defender_found (rsp.defender_found),
  .defender_id    (rsp.defender_id),
  .hunter_found   (rsp.hunter_found),
  .hunter_id      (rsp.hunter_id),
  .bard_found     (rsp.bard_found),
  .bard_id        (rsp.bard_id),
  .group_ready    (rsp.group_ready),
  .push_rejected  (rsp.push_rejected)
);

// ===== sim/role_matching_queue_test.sv =====
// Self-checking testbench for the role matching queue: directed, full-queue, stall and random tests.
module role_matching_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmq_pkg::*;

  // Run limits. The slowest legal item is a group pop on a full queue;
  // on top of that come the longest idle_gap() sender gap and receiver stall
  // per word, plus one HOLD_CYCLES hold-off.
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int TAIL_CYCLES  = 2 * QUEUE_DEPTH + 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 200;
  localparam int NUM_PHASES   = 8;

  // One response word as the block should present it.
  typedef struct packed {
    logic [QCOUNT_BITS-1:0] queue_count;
    logic                   defender_found;
    logic [PID_BITS-1:0]    defender_id;
    logic                   hunter_found;
    logic [PID_BITS-1:0]    hunter_id;
    logic                   bard_found;
    logic [PID_BITS-1:0]    bard_id;
    logic                   group_ready;
    logic                   push_rejected;
  } status_word_t;

  logic clk = 1'b0;
  logic rst;

  rmq_req_if req_ch ();
  rmq_rsp_if rsp_ch ();

  role_matching_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the waiting line, front at index 0, plus the status words
  // predicted for accepted requests that have not come back yet.
  entry_t       waiting[$];
  status_word_t pending_status[$];

  int fail_count        = 0;
  int cycle_count       = 0;

  // Traffic shaping knobs, set by the tests.
  bit req_steady        = 1'b0;  // sender offers back to back, no gaps
  bit rsp_steady        = 1'b0;  // receiver keeps ready high
  int rsp_hold_request  = 0;     // nonzero asks the receiver for a long hold-off

  // Gap length: mostly none, often a few cycles, now and then a long one.
  function automatic int idle_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Index of the frontmost waiting entry with role r, -1 when absent.
  function automatic int front_of(role_t r);
    for (int i = 0; i < waiting.size(); i++) begin
      if (waiting[i].role == r) return i;
    end
    return -1;
  endfunction

  // Remove the frontmost entry of role r; the rest close up behind it.
  function automatic void drop_front(role_t r);
    int idx;
    idx = front_of(r);
    if (idx >= 0) waiting.delete(idx);
  endfunction

  // Apply one request to the shadow queue and build the status word that
  // should follow it.
  function automatic status_word_t predict_status(action_t act, logic [PID_BITS-1:0] pid,
                                                   role_t r);
    status_word_t        s;
    entry_t              e;
    int                  idx;
    logic [2:0]          found;
    logic [PID_BITS-1:0] front_id [3];
    s = '0;
    case (act)
      ACT_PUSH: begin
        if (waiting.size() >= QUEUE_DEPTH) begin
          s.push_rejected = 1'b1;        // full: dropped, nothing changes
        end else begin
          e.id   = pid;
          e.role = r;
          waiting.push_back(e);
        end
      end
      ACT_POP_ROLE: drop_front(r);
      ACT_POP_GROUP: begin
        if (front_of(ROLE_DEFENDER) >= 0 && front_of(ROLE_HUNTER) >= 0 &&
            front_of(ROLE_BARD) >= 0) begin
          drop_front(ROLE_DEFENDER);
          drop_front(ROLE_HUNTER);
          drop_front(ROLE_BARD);
        end
      end
      default: ;                          // query only
    endcase
    for (int k = 0; k < 3; k++) begin
      idx         = front_of(role_t'(k));
      found[k]    = (idx >= 0);
      front_id[k] = (idx >= 0) ? waiting[idx].id : '0;
    end
    s.queue_count    = QCOUNT_BITS'(waiting.size());
    s.defender_found = found[0];
    s.defender_id    = front_id[0];
    s.hunter_found   = found[1];
    s.hunter_id      = front_id[1];
    s.bard_found     = found[2];
    s.bard_id        = front_id[2];
    s.group_ready    = &found;
    return s;
  endfunction

  function automatic void check_field(string name, logic [PID_BITS-1:0] want_v,
                                      logic [PID_BITS-1:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endfunction

  // Random request fields. Ids lean toward the extremes now and then; the
  // spare role code shows up rarely; a phase may favor one real role.
  function automatic logic [PID_BITS-1:0] pick_id();
    int p;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 16) return '1;
    return PID_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic role_t pick_role(int favored);
    int p;
    p = $urandom_range(99);
    if (p < 8) return ROLE_SPARE;
    if (p < 40 && favored >= 0) return role_t'(favored);
    return role_t'($urandom_range(0, 2));
  endfunction

  function automatic action_t pick_action(int push_pct);
    int p;
    if ($urandom_range(99) < push_pct) return ACT_PUSH;
    p = $urandom_range(99);
    if (p < 45) return ACT_POP_ROLE;
    if (p < 80) return ACT_POP_GROUP;
    return ACT_QUERY;
  endfunction

  // Offer one request word and hold it until the block takes it. Valid is
  // left high on acceptance so a following word can go out back to back.
  task automatic send_request(action_t act, logic [PID_BITS-1:0] pid, role_t r);
    int gap;
    gap = req_steady ? 0 : idle_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.player_id <= pid;
    req_ch.role      <= r;
    do @(posedge clk); while (!req_ch.ready);
    pending_status.push_back(predict_status(act, pid, r));
  endtask

  task automatic send_random(int push_pct, int favored);
    send_request(pick_action(push_pct), pick_id(), pick_role(favored));
  endtask

  // Sender stops offering until every outstanding response has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  // Empty-queue corner cases, id extremes, every action, the spare role,
  // a group pop with one role missing and one that succeeds.
  task automatic test_directed();
    send_request(ACT_QUERY,     16'h0000, ROLE_DEFENDER);
    send_request(ACT_POP_ROLE,  16'hFFFF, ROLE_DEFENDER);   // nothing to remove
    send_request(ACT_POP_GROUP, 16'h0000, ROLE_BARD);       // empty, no group
    send_request(ACT_PUSH,      16'h0000, ROLE_DEFENDER);
    send_request(ACT_PUSH,      16'hFFFF, ROLE_HUNTER);
    send_request(ACT_POP_GROUP, 16'h0000, ROLE_DEFENDER);   // bard missing
    send_request(ACT_PUSH,      16'h1234, ROLE_SPARE);      // stored, never reported
    send_request(ACT_PUSH,      16'h8001, ROLE_BARD);
    send_request(ACT_QUERY,     16'hFFFF, ROLE_SPARE);      // group ready now
    send_request(ACT_PUSH,      16'h7FFE, ROLE_DEFENDER);
    send_request(ACT_PUSH,      16'h5555, ROLE_HUNTER);
    send_request(ACT_POP_ROLE,  16'h0000, ROLE_SPARE);      // removes the spare entry
    send_request(ACT_POP_ROLE,  16'h0000, ROLE_SPARE);      // none left
    send_request(ACT_POP_GROUP, 16'hAAAA, ROLE_HUNTER);     // full group leaves
    send_request(ACT_POP_ROLE,  16'h0000, ROLE_BARD);       // bard now absent
    send_request(ACT_PUSH,      16'h00FF, ROLE_BARD);
    send_request(ACT_PUSH,      16'hFF00, ROLE_DEFENDER);
    send_request(ACT_POP_ROLE,  16'h0000, ROLE_DEFENDER);   // front defender, the rest close up
    send_request(ACT_POP_ROLE,  16'h0000, ROLE_HUNTER);
    send_request(ACT_POP_ROLE,  16'h0000, ROLE_HUNTER);     // absent
    send_request(ACT_QUERY,     16'h0000, ROLE_BARD);
  endtask

  // Fill to the brim, bounce pushes off the full queue, free one slot and
  // refill it, then knock one group out.
  task automatic test_full_queue();
    while (waiting.size() < QUEUE_DEPTH) send_random(100, -1);
    repeat (3) send_request(ACT_PUSH, pick_id(), pick_role(-1));
    send_request(ACT_QUERY,     16'h0000, ROLE_DEFENDER);
    send_request(ACT_POP_ROLE,  16'h0000, ROLE_HUNTER);
    send_request(ACT_PUSH,      16'hFFFF, ROLE_SPARE);
    send_request(ACT_PUSH,      16'h0000, ROLE_BARD);
    send_request(ACT_POP_GROUP, 16'h0000, ROLE_DEFENDER);
    send_request(ACT_PUSH,      16'hC3C3, ROLE_BARD);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back to back: the response register fills, the next request parks in
  // its last step, and the request side must stall.
  task automatic test_backpressure();
    req_steady       = 1'b1;
    rsp_hold_request = HOLD_CYCLES;
    repeat (30) send_random(50, -1);
    req_steady       = 1'b0;
    wait_drained();
  endtask

  // Random phases that sweep the fill level: push-heavy phases hit the
  // full queue, pop-heavy ones run it dry. Traffic modes change by phase,
  // and some phases end with the sender waiting for a full drain.
  task automatic test_random_mix();
    int push_mix [NUM_PHASES] = '{85, 35, 60, 97, 15, 55, 75, 45};
    int favor    [NUM_PHASES] = '{-1, 0, 1, 2, -1, 2, -1, 0};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      req_steady = (ph % 3 == 1);
      rsp_steady = (ph % 4 == 2);
      repeat (PHASE_WORDS) send_random(push_mix[ph], favor[ph]);
      if (ph % 2 == 1) wait_drained();
    end
    req_steady = 1'b0;
    rsp_steady = 1'b0;
  endtask

  // Response side ready: random stalls, or steady, or a requested long
  // hold-off counted down here.
  initial begin : rsp_ready_gen
    int stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        if (rsp_hold_request != 0) begin
          stall_left       = rsp_hold_request;
          rsp_hold_request = 0;
        end
        if (stall_left == 0 && !rsp_steady) stall_left = idle_gap();
        if (stall_left > 0) begin
          stall_left--;
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Every response word taken is matched against the oldest prediction.
  always @(posedge clk) begin : rsp_check
    status_word_t got;
    status_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.queue_count    = rsp_ch.queue_count;
      got.defender_found = rsp_ch.defender_found;
      got.defender_id    = rsp_ch.defender_id;
      got.hunter_found   = rsp_ch.hunter_found;
      got.hunter_id      = rsp_ch.hunter_id;
      got.bard_found     = rsp_ch.bard_found;
      got.bard_id        = rsp_ch.bard_id;
      got.group_ready    = rsp_ch.group_ready;
      got.push_rejected  = rsp_ch.push_rejected;
      if (pending_status.size() == 0) begin
        fail_count++;
        $display("%0t ns: response word with none expected, expected none, got %h",
                 $time, got);
      end else begin
        want = pending_status.pop_front();
        check_field("queue_count",    PID_BITS'(want.queue_count),
                    PID_BITS'(got.queue_count));
        check_field("defender_found", PID_BITS'(want.defender_found),
                    PID_BITS'(got.defender_found));
        check_field("defender_id",    want.defender_id,    got.defender_id);
        check_field("hunter_found",   PID_BITS'(want.hunter_found),
                    PID_BITS'(got.hunter_found));
        check_field("hunter_id",      want.hunter_id,      got.hunter_id);
        check_field("bard_found",     PID_BITS'(want.bard_found),
                    PID_BITS'(got.bard_found));
        check_field("bard_id",        want.bard_id,        got.bard_id);
        check_field("group_ready",    PID_BITS'(want.group_ready),
                    PID_BITS'(got.group_ready));
        check_field("push_rejected",  PID_BITS'(want.push_rejected),
                    PID_BITS'(got.push_rejected));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d words outstanding", $time, pending_status.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_QUERY;
    req_ch.player_id = '0;
    req_ch.role      = ROLE_DEFENDER;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_queue();
    test_backpressure();
    test_random_mix();

    // Everything sent: wait for the last responses, then a quiet tail in
    // case the block emits something it should not.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
